### design/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg
// Shared types and constants of the touch sample filter.
// ----------------------------------------------------------------------------
package tsf_pkg;

	localparam int AverageDepthDefault = 4;
	localparam int AverageShiftDefault = 2;
	localparam int ClampMinDefault     = -32768;
	localparam int ClampMaxDefault     = 32767;

	localparam logic [11:0] PenThreshold = 12'd50;

	localparam logic [2:0] RegMode  = 3'd0;
	localparam logic [2:0] RegScale = 3'd7;

	localparam logic [1:0] EvMove = 2'd0;
	localparam logic [1:0] EvDown = 2'd1;
	localparam logic [1:0] EvUp   = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;      // capture the input item
		logic mul_start; // start one product
		logic div_start; // start one division
		logic fin;       // finish: update state, build the result
		logic out_take;  // result register consumed
	} tsf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_cal;  // averaged sample needs calibration
		logic early;     // item only accumulates, no further work
		logic div_busy;
		logic mul_done;
	} tsf_sts_t;

endpackage

### design/tsf_div.sv
// ----------------------------------------------------------------------------
// tsf_div
// Signed 66/32 bit restoring divider, one quotient bit per cycle, truncates
// toward zero.
// ----------------------------------------------------------------------------
module tsf_div import tsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [65:0] dividend,
	input  logic signed [31:0] divisor,
	output logic               busy,
	output logic signed [65:0] quotient
);

	logic [65:0] rem_q;
	logic [65:0] quo_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic [66:0] trial;
	logic [66:0] shifted;

	assign shifted = {rem_q, quo_q[65]};
	assign trial   = shifted - {35'd0, den_q};
	assign busy    = (cnt_q != 7'd0);
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd66;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[65] ? -dividend : dividend;
			den_q <= divisor[31] ? -divisor : divisor;
			neg_q <= dividend[65] ^ divisor[31];
		end else if (busy) begin
			if (!trial[66]) begin
				rem_q <= trial[65:0];
				quo_q <= {quo_q[64:0], 1'b1};
			end else begin
				rem_q <= shifted[65:0];
				quo_q <= {quo_q[64:0], 1'b0};
			end
		end
	end

endmodule

### design/tsf_datapath.sv
// ----------------------------------------------------------------------------
// tsf_datapath
// Sums, calibration arithmetic, held position, pen state and result register.
// ----------------------------------------------------------------------------
module tsf_datapath import tsf_pkg::*; #(
	parameter int AVERAGE_DEPTH = AverageDepthDefault,
	parameter int AVERAGE_SHIFT = AverageShiftDefault,
	parameter int CLAMP_MIN     = ClampMinDefault,
	parameter int CLAMP_MAX     = ClampMaxDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  tsf_cmd_t    cmd,
	output tsf_sts_t    sts,
	input  logic [35:0] in_data,
	input  logic [1:0]  mode,
	input  logic [31:0] coef [7],
	output logic        res_valid,
	output logic [33:0] res_data
);

	logic [11:0] px_q, py_q;
	logic        down_q;
	logic [23:0] sum_x_q, sum_y_q;
	logic [4:0]  cnt_q;
	logic        pen_q, last_q;
	logic signed [17:0] held_x_q, held_y_q;
	logic        avg_q;      // item carries an averaged sample
	logic        cal_q;      // cal_x_q and cal_y_q hold calibrated values
	logic [1:0]  ph_q;       // which product / division is running
	logic signed [65:0] acc_q;
	logic signed [63:0] prod_q;
	logic        pdone_q;
	logic signed [65:0] cal_x_q, cal_y_q;
	logic        div_busy;
	logic        div_busy_q;
	logic signed [65:0] quo;

	logic signed [31:0] avg_x, avg_y;
	logic signed [31:0] mul_a, mul_b;
	logic        raw, down_in;

	assign raw     = mode[1];
	assign down_in = in_data[35:24] > PenThreshold;
	assign avg_x   = $signed({8'd0, sum_x_q >> AVERAGE_SHIFT});
	assign avg_y   = $signed({8'd0, sum_y_q >> AVERAGE_SHIFT});

	// Product schedule: a*x, b*y, d*x, e*y.
	assign mul_a = ph_q[0] ? (ph_q[1] ? $signed(coef[4]) : $signed(coef[1]))
	                       : (ph_q[1] ? $signed(coef[3]) : $signed(coef[0]));
	assign mul_b = ph_q[0] ? avg_y : avg_x;

	assign sts.need_cal = avg_q && (coef[6] != 32'd0) && !raw;
	assign sts.early    = mode[0] && down_q
		&& (cnt_q != 5'(AVERAGE_DEPTH));
	assign sts.div_busy = div_busy;
	assign sts.mul_done = pdone_q;

	tsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (acc_q),
		.divisor  ($signed(coef[6])),
		.busy     (div_busy),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q   <= in_data[11:0];
			py_q   <= in_data[23:12];
			down_q <= down_in;
			avg_q  <= mode[0] && down_in && (cnt_q == 5'(AVERAGE_DEPTH));
			ph_q   <= 2'd0;
		end
		if (cmd.mul_start) begin
			prod_q <= mul_a * mul_b;
		end
		if (pdone_q) begin
			if (ph_q[0]) begin
				acc_q <= acc_q + 66'(prod_q)
					+ (ph_q[1] ? 66'($signed(coef[5])) : 66'($signed(coef[2])));
			end else begin
				acc_q <= 66'(prod_q);
			end
			ph_q <= ph_q + 2'd1;
		end
		if (!div_busy && div_busy_q) begin
			if (ph_q == 2'd2) cal_x_q <= quo;
			else cal_y_q <= quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pdone_q    <= 1'b0;
			cal_q      <= 1'b0;
			div_busy_q <= 1'b0;
		end else begin
			pdone_q    <= cmd.mul_start;
			cal_q      <= cmd.load ? 1'b0 : (cal_q | cmd.div_start);
			div_busy_q <= div_busy;
		end
	end

	// Final position of this item.
	logic signed [65:0] nx, ny;
	logic signed [17:0] fx, fy;
	logic signed [17:0] hx_n, hy_n;
	logic               pen_n, chg;
	logic signed [18:0] dx, dy;
	logic               neg_x, neg_y;
	logic [38:0]        qx;
	logic [42:0]        qy;
	logic [15:0]        sx, sy;

	function automatic logic signed [17:0] clampv(input logic signed [65:0] v);
		if (v < 66'(CLAMP_MIN)) return 18'(CLAMP_MIN);
		if (v > 66'(CLAMP_MAX)) return 18'(CLAMP_MAX);
		return 18'(v);
	endfunction

	always_comb begin
		if (avg_q && cal_q) begin
			nx = cal_x_q;
			ny = cal_y_q;
		end else if (avg_q) begin
			nx = 66'(avg_x);
			ny = 66'(avg_y);
		end else begin
			nx = 66'($signed({1'b0, px_q}));
			ny = 66'($signed({1'b0, py_q}));
		end
		fx    = raw ? 18'(nx) : clampv(nx);
		fy    = raw ? 18'(ny) : clampv(ny);
		pen_n = down_q;
		hx_n  = held_x_q;
		hy_n  = held_y_q;
		chg   = (pen_q != down_q);
		if (down_q && (fx != held_x_q || fy != held_y_q)) begin
			chg  = 1'b1;
			hx_n = fx;
			hy_n = fy;
		end
		// The scale factors reduce to 8/7 and 32/31. A screen value is negative
		// exactly when its distance is negative; otherwise the divisions by 7
		// and 31 use reciprocal multiplication, exact over the position range.
		dx    = 19'sd220 - 19'(hx_n);
		dy    = 19'sd310 - 19'(hy_n);
		neg_x = dx[18];
		neg_y = dy[18];
		qx    = 39'({dx[15:0], 3'b000}) * 39'd599187;
		qy    = 43'({dy[15:0], 5'b00000}) * 43'd2164803;
		sx    = qx[37:22];
		sy    = qy[41:26];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q   <= '0;
			sum_y_q   <= '0;
			cnt_q     <= '0;
			pen_q     <= 1'b0;
			last_q    <= 1'b0;
			held_x_q  <= '0;
			held_y_q  <= '0;
			res_valid <= 1'b0;
		end else begin
			if (cmd.out_take) res_valid <= 1'b0;
			if (cmd.fin) begin
				if (mode[0] && (!down_q || avg_q)) begin
					sum_x_q <= '0;
					sum_y_q <= '0;
					cnt_q   <= '0;
				end
				if (sts.early) begin
					sum_x_q <= sum_x_q + 24'(px_q);
					sum_y_q <= sum_y_q + 24'(py_q);
					cnt_q   <= cnt_q + 5'd1;
				end else begin
					pen_q    <= pen_n;
					held_x_q <= hx_n;
					held_y_q <= hy_n;
					if (chg) begin
						last_q <= pen_n;
						if (!neg_x && !neg_y) begin
							res_valid <= 1'b1;
							res_data  <= {(last_q && pen_n) ? EvMove :
								(!last_q && pen_n) ? EvDown : EvUp,
								sy, sx};
						end
					end
				end
			end
		end
	end

endmodule

### design/tsf_ctrl.sv
// ----------------------------------------------------------------------------
// tsf_ctrl
// Capture, then four products, two divisions if calibrated, finish.
// ----------------------------------------------------------------------------
module tsf_ctrl import tsf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_fire,
	input  logic     out_fire,
	input  logic     res_valid,
	input  tsf_sts_t sts,
	output tsf_cmd_t cmd,
	output logic     in_ready
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EVAL = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_MWT  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_n;
	logic [2:0] step_q, step_n; // products done
	logic       wait_q, wait_n;

	assign in_ready = (state_q == ST_IDLE) && !res_valid;

	always_comb begin
		state_n = state_q;
		step_n  = step_q;
		wait_n  = wait_q;
		cmd     = '0;
		cmd.out_take = out_fire;
		cmd.load     = in_fire;
		case (state_q)
			ST_IDLE: if (in_fire) state_n = ST_EVAL;
			ST_EVAL: begin
				step_n = '0;
				if (!sts.early && sts.need_cal) state_n = ST_MUL;
				else state_n = ST_FIN;
			end
			ST_MUL: begin
				cmd.mul_start = 1'b1;
				state_n = ST_MWT;
			end
			ST_MWT: if (sts.mul_done) begin
				step_n = step_q + 3'd1;
				if (step_q[0]) begin
					// The sum is complete in the next cycle; start the division then.
					wait_n  = 1'b1;
					state_n = ST_DIV;
				end else state_n = ST_MUL;
			end
			ST_DIV: begin
				wait_n = 1'b0;
				if (wait_q) cmd.div_start = 1'b1;
				else if (!sts.div_busy)
					state_n = (step_q == 3'd4) ? ST_FIN : ST_MUL;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			wait_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			step_q  <= step_n;
			wait_q  <= wait_n;
		end
	end

endmodule

### design/touch_sample_filter_top.sv
// ----------------------------------------------------------------------------
// touch_sample_filter_top
// Averages touch samples, calibrates them and reports pen events.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_axis    in         tdata = raw_x, raw_y, pressure
//  m_axis    out        tdata = screen_x, screen_y; tuser = event_kind
//  cfg       in         wr_en, wr_index, wr_data
//
// An item that only accumulates or needs no calibration is taken,
// evaluated and finished. A calibrated average also runs four
// products and two divisions on the one-bit-per-cycle divider.
// Reset clears control, sums, pen state, flags and configuration.
// A new item is taken only after the result register has been emptied.
// ----------------------------------------------------------------------------
module touch_sample_filter_top import tsf_pkg::*; #(
	parameter int AVERAGE_DEPTH = AverageDepthDefault,
	parameter int AVERAGE_SHIFT = AverageShiftDefault,
	parameter int CLAMP_MIN     = ClampMinDefault,
	parameter int CLAMP_MAX     = ClampMaxDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // raw_x, raw_y, pressure, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // screen_x, screen_y
	output logic [1:0]  m_axis_tuser,  // event_kind
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data
);

	logic [1:0]  mode_q;
	logic [31:0] coef_q [7];
	tsf_cmd_t    cmd;
	tsf_sts_t    sts;
	logic [33:0] res;

	// Configuration registers; index zero is the mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			for (int i = 0; i < 7; i++) coef_q[i] <= '0;
		end else if (wr_en) begin
			if (wr_index == RegMode) mode_q <= wr_data[1:0];
			else coef_q[3'(wr_index - 3'd1)] <= wr_data;
		end
	end

	tsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (s_axis_tvalid && s_axis_tready),
		.out_fire  (m_axis_tvalid && m_axis_tready),
		.res_valid (m_axis_tvalid),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (s_axis_tready)
	);

	tsf_datapath #(
		.AVERAGE_DEPTH (AVERAGE_DEPTH),
		.AVERAGE_SHIFT (AVERAGE_SHIFT),
		.CLAMP_MIN     (CLAMP_MIN),
		.CLAMP_MAX     (CLAMP_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (s_axis_tdata[35:0]),
		.mode      (mode_q),
		.coef      (coef_q),
		.res_valid (m_axis_tvalid),
		.res_data  (res)
	);

	assign m_axis_tdata = res[31:0];
	assign m_axis_tuser = res[33:32];

endmodule

### design/tsf_checker.sv
// ----------------------------------------------------------------------------
// tsf_checker
// Port-level checks of the touch sample filter.
// ----------------------------------------------------------------------------
module tsf_checker import tsf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser != 2'd3) else $error("bad event kind");

	a_no_take_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken while full");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken twice in a row");

endmodule

bind touch_sample_filter_top tsf_checker u_chk (.*);
